### hw/rtl/rc_pkg.sv
// rc_pkg: shared types, constants and character mapping functions
// for the radix conversion block; no dependencies
`default_nettype none

package rc_pkg;

   // default sizes
   localparam int DEF_VALUE_BITS = 32;
   localparam int DEF_MAX_DIGITS = 32;

   // field and register widths
   localparam int CHAR_BITS      = 8;
   localparam int BASE_BITS      = 6;
   localparam int CSR_INDEX_BITS = 4;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_BASE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_BASE = CSR_INDEX_BITS'(1);

   // reset values
   localparam logic [BASE_BITS-1:0] SOURCE_BASE_RESET = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] TARGET_BASE_RESET = BASE_BITS'(2);
   localparam logic [BASE_BITS-1:0] MIN_TARGET_BASE   = BASE_BITS'(2);

   // ascii codes
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER = 8'd65;
   localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd55;
   localparam logic [BASE_BITS-1:0] DIGIT_NINE = BASE_BITS'(9);

   typedef struct packed {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 last_digit;
   } rc_req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] out_char;
      logic                 out_last;
   } rc_rsp_type;

   // signed digit value of an incoming character
   function automatic logic [CHAR_BITS-1:0] char_to_digit(input logic [CHAR_BITS-1:0] code);
      char_to_digit = (code > CHAR_NINE) ? (code - LETTER_OFS) : (code - CHAR_ZERO);
   endfunction

   // ascii code of an outgoing digit
   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [BASE_BITS-1:0] d);
      logic [CHAR_BITS-1:0] dw;
      dw = CHAR_BITS'(d);
      digit_to_char = (d <= DIGIT_NINE) ? (CHAR_ZERO + dw) : (LETTER_OFS + dw);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/rc_divider.sv
// rc_divider: restoring divider, one quotient bit per cycle
// divides a VALUE_BITS dividend by a 6-bit divisor; uses rc_pkg
`default_nettype none

module rc_divider #(
   parameter int VALUE_BITS = rc_pkg::DEF_VALUE_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [VALUE_BITS-1:0]          dividend,
   input  wire logic [rc_pkg::BASE_BITS-1:0]   divisor,
   output logic                                done,
   output logic [VALUE_BITS-1:0]               quotient,
   output logic [rc_pkg::BASE_BITS-1:0]        remainder
);
   import rc_pkg::*;

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [BASE_BITS-1:0]  rem_ff, rem_in;
   logic [BASE_BITS-1:0]  dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [BASE_BITS:0]    shifted;
   logic                  fits;

   // partial remainder with next dividend bit shifted in
   assign shifted = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_BITS'(VALUE_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? BASE_BITS'(shifted - {1'b0, dvs_ff}) : shifted[BASE_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### hw/rtl/radix_conversion.sv
// radix_conversion: top level, accumulates digits in one base and emits them in another
// uses rc_pkg and rc_divider
// a character that is not the last is accepted and busy stays low; a last character runs the
// single bit-serial divider once per output digit, then each digit is read back from the store
// and emitted msd first, a store read before each result strobe; the receiver cannot stall
// reset: synchronous, clears accumulator, sequencer and bases (source 10, target 2)
`default_nettype none

module radix_conversion #(
   parameter int VALUE_BITS = rc_pkg::DEF_VALUE_BITS,
   parameter int MAX_DIGITS = rc_pkg::DEF_MAX_DIGITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire rc_pkg::rc_req_type                 req,
   // result channel
   output logic                                    rsp_strobe,
   output rc_pkg::rc_rsp_type                      rsp,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [rc_pkg::BASE_BITS-1:0]       csr_data
);
   import rc_pkg::*;

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   // sequencer codes
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_DIV_START = 3'd1;
   localparam logic [2:0] ST_DIV_WAIT  = 3'd2;
   localparam logic [2:0] ST_READ      = 3'd3;
   localparam logic [2:0] ST_SHOW      = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [BASE_BITS-1:0]  src_base_ff, src_base_in;
   logic [BASE_BITS-1:0]  tgt_base_ff, tgt_base_in;
   logic [BASE_BITS-1:0]  div_base_ff, div_base_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [BASE_BITS-1:0]  rd_data_ff;

   // digit store, written lsd first, read back msd first
   logic [BASE_BITS-1:0]  digit_mem [MAX_DIGITS];

   logic                  accept;
   logic                  csr_write;
   logic [CHAR_BITS-1:0]  digit;
   logic [VALUE_BITS-1:0] next_value;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quo;
   logic [BASE_BITS-1:0]  div_rem;
   logic                  mem_we;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // value * base + sign-extended digit, wraps at VALUE_BITS
   assign digit      = char_to_digit(req.digit_char);
   assign next_value = VALUE_BITS'(acc_ff * VALUE_BITS'(src_base_ff))
                       + {{(VALUE_BITS-CHAR_BITS){digit[CHAR_BITS-1]}}, digit};

   rc_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == ST_DIV_START),
      .dividend  (val_ff),
      .divisor   (div_base_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign mem_we = (state_ff == ST_DIV_WAIT) && div_done;

   always_comb begin
      state_in    = state_ff;
      src_base_in = src_base_ff;
      tgt_base_in = tgt_base_ff;
      div_base_in = div_base_ff;
      acc_in      = acc_ff;
      val_in      = val_ff;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_SOURCE_BASE: src_base_in = csr_data;
            CSR_TARGET_BASE: tgt_base_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.last_digit) begin
                  // hand the finished value to the divider loop, restart accumulation
                  acc_in      = '0;
                  val_in      = next_value;
                  cnt_in      = '0;
                  div_base_in = (tgt_base_ff < MIN_TARGET_BASE) ? MIN_TARGET_BASE
                                                               : tgt_base_ff;
                  state_in    = ST_DIV_START;
               end else begin
                  acc_in = next_value;
               end
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               cnt_in = cnt_ff + CW'(1);
               val_in = div_quo;
               // stop when the quotient runs out or the store is full
               if (div_quo == '0 || cnt_ff == CW'(MAX_DIGITS - 1)) begin
                  ptr_in   = cnt_ff[AW-1:0];
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in   = ptr_ff - AW'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         src_base_ff <= SOURCE_BASE_RESET;
         tgt_base_ff <= TARGET_BASE_RESET;
         acc_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         src_base_ff <= src_base_in;
         tgt_base_ff <= tgt_base_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
      end
      div_base_ff <= div_base_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
   end

   // digit store write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[cnt_ff[AW-1:0]] <= div_rem;
      end
   end

   // digit store registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= digit_mem[ptr_ff];
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = (state_ff == ST_SHOW);
   assign rsp.out_char = digit_to_char(rd_data_ff);
   assign rsp.out_last = (ptr_ff == '0);

endmodule

`default_nettype wire

### hw/rtl/rc_checker.sv
// rc_checker: port-level checks on the radix conversion top level, bound to it
// uses rc_pkg
`default_nettype none

module rc_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire rc_pkg::rc_req_type req,
   input  wire logic               rsp_strobe,
   input  wire rc_pkg::rc_rsp_type rsp
);
   import rc_pkg::*;

   // results only appear while a conversion is running
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // emitted digits are spaced by the store read cycle
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("back to back result strobes");

   // a last character starts a conversion
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.last_digit) |=> busy)
      else $error("last character did not start a conversion");

   // the final digit ends the conversion
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.out_last) |=> !busy)
      else $error("busy after final digit");

   // a conversion only ends with its final digit
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(rsp_strobe && rsp.out_last))
      else $error("conversion ended without final digit");

endmodule

bind radix_conversion rc_checker u_rc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req        (req),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

`default_nettype wire
